[sv/sws_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and defaults for the stack with sorted readout.
package sws_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int VALUE_W       = 32;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [1:0] ACT_PUSH = 2'd0;
   localparam logic [1:0] ACT_POP  = 2'd1;
   localparam logic [1:0] ACT_DUMP = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [1:0] {
      CMD_PUSH,
      CMD_POP,
      CMD_DUMP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type                kind;
      logic signed [VALUE_W-1:0]   page;
   } cmd_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_POP,
      BACK_SCAN,
      BACK_EMIT
   } back_state_type;

endpackage

[sv/sws_front.sv]
`timescale 1ns / 1ps
// Front end: accepts request beats, decodes the action and hands commands to the queue.
module sws_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_action,
   input  logic signed [sws_pkg::VALUE_W-1:0]   req_page,
   output logic                                 q_push,
   output sws_pkg::cmd_type                     q_cmd,
   input  logic                                 q_ready
);

   logic             hold_valid_ff, hold_valid_in;
   sws_pkg::cmd_type hold_cmd_ff, hold_cmd_in;
   logic             accept;
   logic             known;
   sws_pkg::cmd_kind_type kind;

   assign busy   = hold_valid_ff && !q_ready;
   assign accept = start && !busy;
   assign q_push = hold_valid_ff && q_ready;
   assign q_cmd  = hold_cmd_ff;

   always_comb begin
      known = 1'b1;
      kind  = sws_pkg::CMD_PUSH;
      case (req_action)
         sws_pkg::ACT_PUSH: begin
            kind = sws_pkg::CMD_PUSH;
         end
         sws_pkg::ACT_POP: begin
            kind = sws_pkg::CMD_POP;
         end
         sws_pkg::ACT_DUMP: begin
            kind = sws_pkg::CMD_DUMP;
         end
         default: begin
            known = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (accept) begin
         hold_valid_in = known;
      end else begin
         hold_valid_in = hold_valid_ff && !q_ready;
      end
      if (accept && known) begin
         hold_cmd_in.kind = kind;
         hold_cmd_in.page = req_page;
      end else begin
         hold_cmd_in = hold_cmd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_cmd_ff <= hold_cmd_in;
   end

endmodule

[sv/sws_cmd_queue.sv]
`timescale 1ns / 1ps
// Short command queue between the front end and the stack engine.
module sws_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sws_pkg::cmd_type push_cmd,
   output logic             ready,
   input  logic             pop,
   output logic             pop_valid,
   output sws_pkg::cmd_type pop_cmd
);

   localparam int Depth = sws_pkg::QUEUE_DEPTH;
   localparam int PtrW  = $clog2(Depth);
   localparam int CntW  = $clog2(Depth + 1);

   sws_pkg::cmd_type entry_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  fill_ff, fill_in;
   logic             do_push, do_pop;

   assign ready     = fill_ff != CntW'(Depth);
   assign pop_valid = fill_ff != '0;
   assign pop_cmd   = entry_ff[rd_ptr_ff];
   assign do_push   = push && ready;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[sv/sws_back.sv]
`timescale 1ns / 1ps
// Stack engine: stack memory, push and pop, and the ascending dump by repeated minimum scans.
module sws_back #(
   parameter int DEPTH = sws_pkg::DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 cmd_valid,
   input  sws_pkg::cmd_type                     cmd,
   output logic                                 cmd_take,
   output logic                                 rsp_strobe,
   output logic signed [sws_pkg::VALUE_W-1:0]   rsp_value,
   output logic [1:0]                           rsp_status,
   output logic                                 rsp_last
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   sws_pkg::back_state_type state_ff, state_in;

   logic signed [sws_pkg::VALUE_W-1:0] stack_mem [DEPTH];
   logic signed [sws_pkg::VALUE_W-1:0] rd_data_ff;
   logic [AW-1:0]                      rd_addr;
   logic                               wr_en;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] issue_ff, issue_in;
   logic [CW-1:0] emitted_ff, emitted_in;
   logic [CW-1:0] mult_ff, mult_in;
   logic [CW-1:0] emitted_plus;
   logic [CW-1:0] count_less;
   logic signed [sws_pkg::VALUE_W-1:0] cand_ff, cand_in;
   logic signed [sws_pkg::VALUE_W-1:0] prev_ff, prev_in;
   logic          have_ff, have_in;
   logic          first_ff, first_in;
   logic          data_valid_ff, data_valid_in;
   logic          eligible;
   logic          final_beat;

   logic                               rsp_strobe_ff, rsp_strobe_in;
   logic signed [sws_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [1:0]                         rsp_status_ff, rsp_status_in;
   logic                               rsp_last_ff, rsp_last_in;

   assign emitted_plus = emitted_ff + CW'(1);
   assign count_less   = count_ff - CW'(1);
   assign final_beat   = emitted_plus == count_ff;
   assign eligible     = first_ff || (rd_data_ff > prev_ff);

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sws_pkg::BACK_IDLE: begin
            if (cmd_valid && count_ff != '0) begin
               if (cmd.kind == sws_pkg::CMD_POP) begin
                  state_in = sws_pkg::BACK_POP;
               end else if (cmd.kind == sws_pkg::CMD_DUMP) begin
                  state_in = sws_pkg::BACK_SCAN;
               end
            end
         end
         sws_pkg::BACK_POP: begin
            state_in = sws_pkg::BACK_IDLE;
         end
         sws_pkg::BACK_SCAN: begin
            if (issue_ff == count_ff && !data_valid_ff) begin
               state_in = sws_pkg::BACK_EMIT;
            end
         end
         sws_pkg::BACK_EMIT: begin
            if (mult_ff == CW'(1)) begin
               state_in = final_beat ? sws_pkg::BACK_IDLE : sws_pkg::BACK_SCAN;
            end
         end
         default: begin
            state_in = sws_pkg::BACK_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd_take      = 1'b0;
      wr_en         = 1'b0;
      rd_addr       = count_less[AW-1:0];
      count_in      = count_ff;
      issue_in      = issue_ff;
      emitted_in    = emitted_ff;
      mult_in       = mult_ff;
      cand_in       = cand_ff;
      prev_in       = prev_ff;
      have_in       = have_ff;
      first_in      = first_ff;
      data_valid_in = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_value_in  = '0;
      rsp_status_in = sws_pkg::STATUS_OK;
      rsp_last_in   = 1'b0;
      case (state_ff)
         sws_pkg::BACK_IDLE: begin
            cmd_take = 1'b1;
            if (cmd_valid) begin
               case (cmd.kind)
                  sws_pkg::CMD_PUSH: begin
                     rsp_strobe_in = 1'b1;
                     rsp_last_in   = 1'b1;
                     if (count_ff == CW'(DEPTH)) begin
                        rsp_status_in = sws_pkg::STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  sws_pkg::CMD_POP: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_last_in   = 1'b1;
                        rsp_status_in = sws_pkg::STATUS_EMPTY;
                     end else begin
                        count_in = count_less;
                     end
                  end
                  sws_pkg::CMD_DUMP: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_last_in   = 1'b1;
                        rsp_status_in = sws_pkg::STATUS_EMPTY;
                     end else begin
                        issue_in   = '0;
                        emitted_in = '0;
                        mult_in    = '0;
                        have_in    = 1'b0;
                        first_in   = 1'b1;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b0;
                  end
               endcase
            end
         end
         sws_pkg::BACK_POP: begin
            rsp_strobe_in = 1'b1;
            rsp_value_in  = rd_data_ff;
            rsp_last_in   = 1'b1;
         end
         sws_pkg::BACK_SCAN: begin
            rd_addr = issue_ff[AW-1:0];
            if (issue_ff != count_ff) begin
               issue_in      = issue_ff + CW'(1);
               data_valid_in = 1'b1;
            end
            if (data_valid_ff && eligible) begin
               if (!have_ff || rd_data_ff < cand_ff) begin
                  cand_in = rd_data_ff;
                  mult_in = CW'(1);
                  have_in = 1'b1;
               end else if (rd_data_ff == cand_ff) begin
                  mult_in = mult_ff + CW'(1);
               end
            end
         end
         sws_pkg::BACK_EMIT: begin
            rsp_strobe_in = 1'b1;
            rsp_value_in  = cand_ff;
            rsp_last_in   = final_beat;
            emitted_in    = emitted_plus;
            mult_in       = mult_ff - CW'(1);
            if (mult_ff == CW'(1) && !final_beat) begin
               prev_in  = cand_ff;
               first_in = 1'b0;
               have_in  = 1'b0;
               issue_in = '0;
            end
         end
         default: begin
            cmd_take = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sws_pkg::BACK_IDLE;
         count_ff      <= '0;
         data_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         data_valid_ff <= data_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff      <= issue_in;
      emitted_ff    <= emitted_in;
      mult_ff       <= mult_in;
      cand_ff       <= cand_in;
      prev_ff       <= prev_in;
      have_ff       <= have_in;
      first_ff      <= first_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[count_ff[AW-1:0]] <= cmd.page;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

endmodule

[sv/stack_with_sorted_dump.sv]
`timescale 1ns / 1ps
// Top level of the LIFO stack with ascending sorted readout.
//
// Request channel: a beat is taken at a rising edge with start high and busy low.
// req_action selects push (value in req_page), pop or dump; the unused action code
// is taken and dropped without a response.
// Response channel: rsp_strobe marks each beat for exactly one cycle; rsp_value,
// rsp_status and rsp_last hold for that cycle only. The receiver cannot stall.
// A front end registers the decoded request into a two-entry command queue; the
// stack engine drains it, so busy rises only when the front register and queue are full.
// A push response passes the front register, the queue and the response register; a pop
// also passes the pop state of the engine. The engine takes one push per cycle while idle;
// a pop holds it in the pop state before it takes the next command.
// Dump of n held values: the engine scans the stack memory once per distinct value over
// its single read port, then emits each copy of that value one per cycle; it takes no
// new command until the last copy is out.
// Reset empties the stack and the queue and clears the response strobe; no clearing
// pass is needed.
module stack_with_sorted_dump #(
   parameter int DEPTH = sws_pkg::DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_action,
   input  logic signed [sws_pkg::VALUE_W-1:0]   req_page,
   output logic                                 rsp_strobe,
   output logic signed [sws_pkg::VALUE_W-1:0]   rsp_value,
   output logic [1:0]                           rsp_status,
   output logic                                 rsp_last
);

   logic             q_push;
   logic             q_ready;
   sws_pkg::cmd_type q_cmd;
   logic             cmd_valid;
   logic             cmd_take;
   sws_pkg::cmd_type cmd;

   sws_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_action (req_action),
      .req_page   (req_page),
      .q_push     (q_push),
      .q_cmd      (q_cmd),
      .q_ready    (q_ready)
   );

   sws_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (q_cmd),
      .ready     (q_ready),
      .pop       (cmd_take),
      .pop_valid (cmd_valid),
      .pop_cmd   (cmd)
   );

   sws_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_take   (cmd_take),
      .rsp_strobe (rsp_strobe),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_last)
   );

`ifndef ASSERT_OFF
   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != sws_pkg::STATUS_OK |-> rsp_last)
      else $error("error response not marked last");

   a_error_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != sws_pkg::STATUS_OK |-> rsp_value == '0)
      else $error("error response carries a nonzero value");

   a_dump_ascending: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && $past(rsp_strobe) && !$past(rsp_last) |-> rsp_value >= $past(rsp_value))
      else $error("dump beats out of ascending order");

   a_queue_feed: assert property (@(posedge clock) disable iff (reset)
      q_push |-> q_ready)
      else $error("command pushed into a full queue");
`endif

endmodule
